// ===== rtl/cbfp_pkg.sv =====
// Package for the CAN bridge frame parser: packet byte codes, result kinds
// and the result record shared by the parser, the output buffer and the top.
// No dependencies.
package cbfp_pkg;

    localparam logic [7:0] START_BYTE   = 8'hAA;
    localparam logic [7:0] TYPE_RX_OK   = 8'h11;
    localparam logic [7:0] TYPE_TX_FAIL = 8'h02;
    localparam logic [7:0] END_BYTE     = 8'h55;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    localparam int unsigned PACKET_LEN = 16;
    localparam int unsigned POS_W      = $clog2(PACKET_LEN);
    localparam logic [POS_W-1:0] POS_START = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ID_LO = POS_W'(3);
    localparam logic [POS_W-1:0] POS_ID_HI = POS_W'(6);
    localparam logic [POS_W-1:0] POS_DT_LO = POS_W'(7);
    localparam logic [POS_W-1:0] POS_DT_HI = POS_W'(14);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_LEN - 1);

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_RESEND = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] can_id;
        logic [63:0] payload;
        logic [15:0] rx_per_second;
        logic [15:0] errors_per_second;
    } cbfp_res_t;

endpackage

// ===== rtl/cbfp_parser.sv =====
// Packet framing state and per-second counters for the CAN bridge parser.
// Produces at most one result per accepted beat. Depends on cbfp_pkg.
module cbfp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic              in_op,
    input  logic [7:0]        in_byte,
    output logic              res_valid,
    output cbfp_pkg::cbfp_res_t res
);
    import cbfp_pkg::*;

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [7:0]       frame_type_reg, frame_type_next;
    logic [31:0]      id_shift_reg, id_shift_next;
    logic [63:0]      data_shift_reg, data_shift_next;
    logic             connected_reg, connected_next;
    logic [15:0]      rx_count_reg, rx_count_next;
    logic [15:0]      error_count_reg, error_count_next;

    always_comb begin
        byte_position_next = byte_position_reg;
        frame_type_next    = frame_type_reg;
        id_shift_next      = id_shift_reg;
        data_shift_next    = data_shift_reg;
        connected_next     = connected_reg;
        rx_count_next      = rx_count_reg;
        error_count_next   = error_count_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (in_accept) begin
            if (in_op == OP_TICK) begin
                res_valid             = 1'b1;
                res.kind              = KIND_REPORT;
                res.rx_per_second     = rx_count_reg;
                res.errors_per_second = error_count_reg;
                rx_count_next         = '0;
                error_count_next      = '0;
            end else if (byte_position_reg == POS_START) begin
                if (in_byte == START_BYTE) begin
                    byte_position_next = POS_TYPE;
                end
            end else if (byte_position_reg == POS_TYPE) begin
                if (in_byte inside {TYPE_RX_OK, TYPE_TX_FAIL}) begin
                    frame_type_next    = in_byte;
                    byte_position_next = byte_position_reg + POS_W'(1);
                end else begin
                    byte_position_next = POS_START;
                end
            end else if (byte_position_reg != POS_LAST) begin
                if (byte_position_reg inside {[POS_ID_LO:POS_ID_HI]}) begin
                    id_shift_next = {in_byte, id_shift_reg[31:8]};
                end else if (byte_position_reg inside {[POS_DT_LO:POS_DT_HI]}) begin
                    data_shift_next = {in_byte, data_shift_reg[63:8]};
                end
                byte_position_next = byte_position_reg + POS_W'(1);
            end else begin
                // trailer byte: packet ends here whatever it holds
                byte_position_next = POS_START;
                if (in_byte == END_BYTE) begin
                    if (frame_type_reg == TYPE_RX_OK) begin
                        connected_next = 1'b1;
                        if (rx_count_reg != COUNT_MAX) begin
                            rx_count_next = rx_count_reg + 16'd1;
                        end
                        res_valid   = 1'b1;
                        res.kind    = KIND_FRAME;
                        res.payload = data_shift_reg;
                        // zero id stands for the low nibble of data byte 0
                        res.can_id  = (id_shift_reg == '0)
                                    ? {28'd0, data_shift_reg[3:0] & NIBBLE_MASK}
                                    : id_shift_reg;
                    end else begin
                        if (error_count_reg != COUNT_MAX) begin
                            error_count_next = error_count_reg + 16'd1;
                        end
                        if (connected_reg) begin
                            res_valid   = 1'b1;
                            res.kind    = KIND_RESEND;
                            res.can_id  = id_shift_reg;
                            res.payload = data_shift_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= POS_START;
            frame_type_reg    <= '0;
            id_shift_reg      <= '0;
            data_shift_reg    <= '0;
            connected_reg     <= 1'b0;
            rx_count_reg      <= '0;
            error_count_reg   <= '0;
        end else begin
            byte_position_reg <= byte_position_next;
            frame_type_reg    <= frame_type_next;
            id_shift_reg      <= id_shift_next;
            data_shift_reg    <= data_shift_next;
            connected_reg     <= connected_next;
            rx_count_reg      <= rx_count_next;
            error_count_reg   <= error_count_next;
        end
    end

    // a tick clears both counts
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_op == OP_TICK) |=> (rx_count_reg == '0 && error_count_reg == '0))
        else $error("counts not cleared after tick");

    // resend requests only go out once connected
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_RESEND) |-> connected_reg)
        else $error("resend request while not connected");

    // past the type byte the stored type is always a legal one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_position_reg != POS_START && byte_position_reg != POS_TYPE)
        |-> (frame_type_reg == TYPE_RX_OK || frame_type_reg == TYPE_TX_FAIL))
        else $error("illegal frame type mid-packet");

endmodule

// ===== rtl/cbfp_out_buf.sv =====
// Two-entry output buffer (result register plus skid) for the parser results.
// Depends on cbfp_pkg.
module cbfp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  cbfp_pkg::cbfp_res_t in_res,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cbfp_pkg::cbfp_res_t out_res
);
    import cbfp_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    cbfp_res_t main_reg, main_next;
    cbfp_res_t skid_reg, skid_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = in_res;
                main_valid_next = in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_next       = in_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // skid only fills behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid full with empty result register");

    // a drained beat with skid full moves skid forward
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid not forwarded");

    // never accept while both entries hold a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && skid_valid_reg) |-> !in_ready)
        else $error("buffer overrun");

endmodule

// ===== rtl/can_bridge_frame_parser.sv =====
// CAN bridge frame parser, top level: link byte framing with result buffer.
// Results are registered: each passes the buffer's result register (or skid, if held).
// Throughput: one beat per cycle; the two-entry output buffer keeps s_ready
// high while a single result waits, so only a second waiting result stalls.
// Reset: synchronous active-low aresetn clears framing state, counters,
// the connected flag and the buffer. Depends on cbfp_pkg, cbfp_parser, cbfp_out_buf.
module can_bridge_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats: link byte or one-second tick
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_byte_in,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_can_id,
    output logic [63:0] m_payload,
    output logic [15:0] m_rx_per_second,
    output logic [15:0] m_errors_per_second
);
    import cbfp_pkg::*;

    logic      in_accept;
    logic      res_valid;
    cbfp_res_t res;
    cbfp_res_t out_res;

    // s_ready comes straight from the skid state, so any beat accepted here
    // always has a slot for its result
    assign in_accept = s_valid && s_ready;

    cbfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_op     (s_op),
        .in_byte   (s_byte_in),
        .res_valid (res_valid),
        .res       (res)
    );

    cbfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_kind              = out_res.kind;
    assign m_can_id            = out_res.can_id;
    assign m_payload           = out_res.payload;
    assign m_rx_per_second     = out_res.rx_per_second;
    assign m_errors_per_second = out_res.errors_per_second;

endmodule
